>>> hw/rtl/acs_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and stream packing constants for the accumulator/stack core
// no dependencies; imported by the core, acs_exec and acs_checker
package acs_pkg;

    localparam int MEM_WORDS_DEF = 65536;

    // stream widths: input 50 bits of fields, output 195 bits, padded to bytes
    localparam int IN_W    = 56;
    localparam int OUT_W   = 200;
    localparam int OUT_PAD = 5;

    // output field offsets inside m_tdata
    localparam int O_STAT_LSB = 0;
    localparam int O_CNT_LSB  = 163;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EXEC  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // stop status codes
    localparam logic [2:0] STAT_RUN   = 3'd0;
    localparam logic [2:0] STAT_HALT  = 3'd1;
    localparam logic [2:0] STAT_PC    = 3'd2;
    localparam logic [2:0] STAT_ADDR  = 3'd3;
    localparam logic [2:0] STAT_SHIFT = 3'd4;
    localparam logic [2:0] STAT_OPC   = 3'd5;

    // instruction opcodes
    localparam logic [7:0] OP_LDC  = 8'd0;
    localparam logic [7:0] OP_ADC  = 8'd1;
    localparam logic [7:0] OP_LDL  = 8'd2;
    localparam logic [7:0] OP_STL  = 8'd3;
    localparam logic [7:0] OP_LDNL = 8'd4;
    localparam logic [7:0] OP_STNL = 8'd5;
    localparam logic [7:0] OP_ADD  = 8'd6;
    localparam logic [7:0] OP_SUB  = 8'd7;
    localparam logic [7:0] OP_SHL  = 8'd8;
    localparam logic [7:0] OP_SHR  = 8'd9;
    localparam logic [7:0] OP_ADJ  = 8'd10;
    localparam logic [7:0] OP_A2SP = 8'd11;
    localparam logic [7:0] OP_SP2A = 8'd12;
    localparam logic [7:0] OP_CALL = 8'd13;
    localparam logic [7:0] OP_RET  = 8'd14;
    localparam logic [7:0] OP_BRZ  = 8'd15;
    localparam logic [7:0] OP_BRLZ = 8'd16;
    localparam logic [7:0] OP_BR   = 8'd17;
    localparam logic [7:0] OP_HALT = 8'd18;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc;
        logic [31:0] sp;
    } arch_t;

    typedef struct packed {
        arch_t       nxt;
        logic [2:0]  status;
        logic        done;
        logic        mem_rd;
        logic        mem_wr;
        logic        push_b;
        logic [31:0] ea;
        logic [31:0] wdata;
    } exec_res_t;

endpackage

>>> hw/rtl/accumulator_stack_cpu_core.sv
`timescale 1ns / 1ps
// from accept to result: writes, unused codes, out-of-range reads and executes on a stopped
// core or bad pc load the output in S_IDLE; in-range reads pass S_RD, executes S_EXEC and
// loads S_EXEC then S_LOAD, the single memory port serving fetch, then one access; an item
// is taken only in S_IDLE, while the output register is empty or being read in that cycle
// reset: synchronous active-low aresetn, then a clearing pass writes every one of the
// MEM_WORDS memory words to zero; s_tready stays low until it ends
module accumulator_stack_cpu_core #(
    parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // opcode[1:0], address[17:2], data[49:18], zero fill
    input  logic [acs_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status[2:0], reg_a[34:3], reg_b[66:35], prog_counter[98:67],
    // stack_pointer[130:99], read_word[162:131], executed_count[194:163], zero fill
    output logic [acs_pkg::OUT_W-1:0] m_tdata
);
    import acs_pkg::*;

    localparam int          AW      = $clog2(MEM_WORDS);
    localparam logic [31:0] MEM_W32 = 32'(MEM_WORDS);
    localparam logic [AW-1:0] LAST  = AW'(MEM_WORDS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_EXEC  = 5'b01000,
        S_LOAD  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_idx_reg;
    logic [31:0]     a_reg, a_next, b_reg, b_next;
    logic [31:0]     pc_reg, pc_next, sp_reg, sp_next;
    logic [2:0]      stat_reg, stat_next;
    logic [31:0]     cnt_reg, cnt_next, cnt_inc;
    logic            push_reg, push_next;
    logic            m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic [1:0]      in_cmd;
    logic [15:0]     in_addr;
    logic [31:0]     in_data;
    logic            in_addr_ok;
    logic            out_free;
    logic            accept;
    logic            out_load;
    logic [31:0]     rd_word;

    logic            mem_en, mem_we;
    logic [AW-1:0]   mem_addr;
    logic [31:0]     mem_wdata, mem_rdata;

    arch_t           cur;
    exec_res_t       res;

    assign in_cmd     = s_tdata[1:0];
    assign in_addr    = s_tdata[17:2];
    assign in_data    = s_tdata[49:18];
    assign in_addr_ok = {16'd0, in_addr} < MEM_W32;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign cnt_inc  = (cnt_reg == 32'hffff_ffff) ? cnt_reg : cnt_reg + 32'd1;

    assign cur.a  = a_reg;
    assign cur.b  = b_reg;
    assign cur.pc = pc_reg;
    assign cur.sp = sp_reg;

    acs_ram #(
        .DEPTH (MEM_WORDS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    acs_exec #(
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .inst (mem_rdata),
        .cur  (cur),
        .res  (res)
    );

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        stat_next  = stat_reg;
        cnt_next   = cnt_reg;
        push_next  = push_reg;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = '0;
        mem_wdata  = '0;
        out_load   = 1'b0;
        rd_word    = '0;
        case (state_reg)
            S_CLEAR: begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = clr_idx_reg;
                if (clr_idx_reg == LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_WRITE: begin
                            mem_en    = in_addr_ok;
                            mem_we    = in_addr_ok;
                            mem_addr  = AW'(in_addr);
                            mem_wdata = in_data;
                            out_load  = 1'b1;
                        end
                        CMD_READ: begin
                            if (in_addr_ok) begin
                                mem_en     = 1'b1;
                                mem_addr   = AW'(in_addr);
                                state_next = S_RD;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        CMD_EXEC: begin
                            if (stat_reg != STAT_RUN) begin
                                out_load = 1'b1;
                            end else if (pc_reg >= MEM_W32) begin
                                stat_next = STAT_PC;
                                out_load  = 1'b1;
                            end else begin
                                // instruction fetch
                                mem_en     = 1'b1;
                                mem_addr   = pc_reg[AW-1:0];
                                state_next = S_EXEC;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                rd_word    = mem_rdata;
                out_load   = 1'b1;
                state_next = S_IDLE;
            end
            S_EXEC: begin
                pc_next = res.nxt.pc;
                if (res.mem_rd) begin
                    mem_en     = 1'b1;
                    mem_addr   = res.ea[AW-1:0];
                    push_next  = res.push_b;
                    state_next = S_LOAD;
                end else begin
                    a_next    = res.nxt.a;
                    b_next    = res.nxt.b;
                    sp_next   = res.nxt.sp;
                    stat_next = res.status;
                    if (res.done) begin
                        cnt_next = cnt_inc;
                    end
                    mem_en     = res.mem_wr;
                    mem_we     = res.mem_wr;
                    mem_addr   = res.ea[AW-1:0];
                    mem_wdata  = res.wdata;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LOAD: begin
                a_next = mem_rdata;
                if (push_reg) begin
                    b_next = a_reg;
                end
                cnt_next   = cnt_inc;
                out_load   = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            pc_reg      <= '0;
            sp_reg      <= '0;
            stat_reg    <= STAT_RUN;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            a_reg    <= a_next;
            b_reg    <= b_next;
            pc_reg   <= pc_next;
            sp_reg   <= sp_next;
            stat_reg <= stat_next;
            cnt_reg  <= cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        push_reg <= push_next;
        if (out_load) begin
            m_data_reg <= {{OUT_PAD{1'b0}}, cnt_next, rd_word, sp_next, pc_next,
                           b_next, a_next, stat_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hw/rtl/acs_ram.sv
`timescale 1ns / 1ps
// single-port word memory, synchronous registered read
// no dependencies
module acs_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

>>> hw/rtl/acs_exec.sv
`timescale 1ns / 1ps
// instruction decode and execute for one fetched word
// depends on acs_pkg
module acs_exec #(
    parameter int MEM_WORDS = 65536
) (
    input  logic [31:0]       inst,
    input  acs_pkg::arch_t    cur,
    output acs_pkg::exec_res_t res
);
    import acs_pkg::*;

    localparam logic [31:0] MEM_W32 = 32'(MEM_WORDS);

    logic [7:0]  op;
    logic [31:0] imm;
    logic [31:0] pc1;
    logic [31:0] base;
    logic [31:0] sum;
    logic        ea_ok;
    logic        is_sub;
    logic [31:0] ba;
    logic [31:0] pct;
    logic [4:0]  shamt;
    logic        sh_ok;

    assign op    = inst[7:0];
    assign imm   = {{8{inst[31]}}, inst[31:8]};
    assign pc1   = cur.pc + 32'd1;
    // one adder serves adc, adj and both address forms
    assign base  = (op == OP_LDL || op == OP_STL || op == OP_ADJ) ? cur.sp : cur.a;
    assign sum   = base + imm;
    assign ea_ok = sum < MEM_W32;
    assign is_sub = (op == OP_SUB);
    assign ba    = cur.b + (is_sub ? ~cur.a : cur.a) + {31'd0, is_sub};
    assign pct   = pc1 + imm;
    assign shamt = cur.a[4:0];
    assign sh_ok = (cur.a[31:5] == 27'd0);

    always_comb begin
        res        = '0;
        res.nxt    = cur;
        res.nxt.pc = pc1;
        res.status = STAT_RUN;
        res.done   = 1'b1;
        res.ea     = sum;
        case (op)
            OP_LDC: begin
                res.nxt.b = cur.a;
                res.nxt.a = imm;
            end
            OP_ADC: begin
                res.nxt.a = sum;
            end
            OP_LDL, OP_LDNL: begin
                if (ea_ok) begin
                    res.mem_rd = 1'b1;
                    res.push_b = (op == OP_LDL);
                end else begin
                    res.status = STAT_ADDR;
                    res.done   = 1'b0;
                end
            end
            OP_STL: begin
                if (ea_ok) begin
                    res.mem_wr = 1'b1;
                    res.wdata  = cur.a;
                    res.nxt.a  = cur.b;
                end else begin
                    res.status = STAT_ADDR;
                    res.done   = 1'b0;
                end
            end
            OP_STNL: begin
                if (ea_ok) begin
                    res.mem_wr = 1'b1;
                    res.wdata  = cur.b;
                end else begin
                    res.status = STAT_ADDR;
                    res.done   = 1'b0;
                end
            end
            OP_ADD, OP_SUB: begin
                res.nxt.a = ba;
            end
            OP_SHL, OP_SHR: begin
                if (sh_ok) begin
                    res.nxt.a = (op == OP_SHL) ? (cur.b << shamt)
                                               : 32'($signed(cur.b) >>> shamt);
                end else begin
                    res.status = STAT_SHIFT;
                    res.done   = 1'b0;
                end
            end
            OP_ADJ: begin
                res.nxt.sp = sum;
            end
            OP_A2SP: begin
                res.nxt.sp = cur.a;
                res.nxt.a  = cur.b;
            end
            OP_SP2A: begin
                res.nxt.b = cur.a;
                res.nxt.a = cur.sp;
            end
            OP_CALL: begin
                res.nxt.b  = cur.a;
                res.nxt.a  = pc1;
                res.nxt.pc = pct;
            end
            OP_RET: begin
                res.nxt.pc = cur.a;
                res.nxt.a  = cur.b;
            end
            OP_BRZ: begin
                if (cur.a == 32'd0) begin
                    res.nxt.pc = pct;
                end
            end
            OP_BRLZ: begin
                if (cur.a[31]) begin
                    res.nxt.pc = pct;
                end
            end
            OP_BR: begin
                res.nxt.pc = pct;
            end
            OP_HALT: begin
                res.status = STAT_HALT;
                res.done   = 1'b0;
            end
            default: begin
                res.status = STAT_OPC;
                res.done   = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/acs_checker.sv
`timescale 1ns / 1ps
// port-level checks on the core's result stream, bound to the top level
// depends on acs_pkg and accumulator_stack_cpu_core
module acs_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [acs_pkg::OUT_W-1:0] m_tdata
);
    import acs_pkg::*;

    logic [2:0]  last_stat_reg;
    logic [31:0] last_cnt_reg;
    logic [2:0]  m_stat;
    logic [31:0] m_cnt;

    assign m_stat = m_tdata[O_STAT_LSB +: 3];
    assign m_cnt  = m_tdata[O_CNT_LSB +: 32];

    // last status and count seen on a delivered item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_stat_reg <= STAT_RUN;
            last_cnt_reg  <= '0;
        end else if (m_tvalid && m_tready) begin
            last_stat_reg <= m_stat;
            last_cnt_reg  <= m_cnt;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_no_out_in_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && last_stat_reg != STAT_RUN |-> m_stat == last_stat_reg)
        else $error("stop status changed after stop");

    a_cnt_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && last_stat_reg != STAT_RUN |-> m_cnt == last_cnt_reg)
        else $error("instruction count moved after stop");

    a_cnt_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_cnt >= last_cnt_reg)
        else $error("instruction count went down");

endmodule

bind accumulator_stack_cpu_core acs_checker u_acs_checker (.*);
